/* rtl/lcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and the init table of the character-LCD command
// sequencer.
// ----------------------------------------------------------------------------
package lcs_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [2:0] {
        REQ_INIT  = 3'd0,
        REQ_CLEAR = 3'd1,
        REQ_HOME  = 3'd2,
        REQ_MOVE  = 3'd3,
        REQ_CHAR  = 3'd4,
        REQ_RAW   = 3'd5
    } req_type_t;

    localparam int REQ_W       = 3;
    localparam int CURSOR_W    = 6;
    localparam int COUNT_W     = 6;
    localparam int IDX_W       = 4;   // addresses the init table
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CURSOR_W-1:0] MAX_CURSOR = 6'd63;
    localparam logic [COUNT_W-1:0]  INIT_LEN   = 6'd9;

    // LCD instructions
    localparam logic [7:0] INS_CLEAR       = 8'h01;
    localparam logic [7:0] INS_HOME        = 8'h03;
    localparam logic [7:0] INS_SHIFT_RIGHT = 8'h14;
    localparam logic [7:0] INS_SHIFT_LEFT  = 8'h10;

    // Expander frame bits below the nibble
    localparam logic [7:0] FRM_BACKLIGHT = 8'h08;
    localparam logic [7:0] FRM_ENABLE    = 8'h04;
    localparam logic [7:0] FRM_RS        = 8'h01;

    // Second display line starts at this DDRAM offset
    localparam logic [CURSOR_W-1:0] LINE2_OFFSET = 6'd40;

    // One queued command: either the init table or a byte repeated count times
    typedef struct packed {
        logic               init_seq;
        logic [7:0]         lcd_byte;
        logic               is_data;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h30;
            4'd1:    b = 8'h30;
            4'd2:    b = 8'h30;
            4'd3:    b = 8'h20;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h06;
            4'd8:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* rtl/lcs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_front
// Accepts requests, tracks the cursor address and turns each request that sends
// something into one queued command.
// ----------------------------------------------------------------------------
module lcs_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,
    input  wire logic [2:0]           s_axis_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output lcs_pkg::cmd_t             q_cmd
);

    logic [lcs_pkg::CURSOR_W-1:0] cursor_reg;
    logic [lcs_pkg::CURSOR_W-1:0] cursor_next;
    logic                         accept;
    logic                         emit;
    lcs_pkg::req_type_t           req;
    logic [7:0]                   char_code;
    logic [4:0]                   column;
    logic [1:0]                   line;
    logic                         move_ok;
    logic [lcs_pkg::CURSOR_W-1:0] target;
    logic                         go_right;
    logic [lcs_pkg::COUNT_W-1:0]  shift_cnt;

    assign char_code = s_axis_tdata[7:0];
    assign column    = s_axis_tdata[12:8];
    assign line      = s_axis_tdata[14:13];
    assign req       = lcs_pkg::req_type_t'(s_axis_tuser);

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign move_ok  = (column <= 5'd15) && (line == 2'd1 || line == 2'd2);
    assign target   = {2'b00, column[3:0]}
                    + ((line == 2'd2) ? lcs_pkg::LINE2_OFFSET : '0);
    assign go_right = (target >= cursor_reg);
    assign shift_cnt = go_right ? (target - cursor_reg) : (cursor_reg - target);

    always_comb
    begin
        cursor_next    = cursor_reg;
        emit           = 1'b0;
        q_cmd.init_seq = 1'b0;
        q_cmd.lcd_byte = char_code;
        q_cmd.is_data  = 1'b0;
        q_cmd.count    = 6'd1;
        case (req)
            lcs_pkg::REQ_INIT:
            begin
                emit           = 1'b1;
                q_cmd.init_seq = 1'b1;
                q_cmd.count    = lcs_pkg::INIT_LEN;
                cursor_next    = '0;
            end
            lcs_pkg::REQ_CLEAR:
            begin
                emit           = 1'b1;
                q_cmd.lcd_byte = lcs_pkg::INS_CLEAR;
                cursor_next    = '0;
            end
            lcs_pkg::REQ_HOME:
            begin
                emit           = 1'b1;
                q_cmd.lcd_byte = lcs_pkg::INS_HOME;
                cursor_next    = '0;
            end
            lcs_pkg::REQ_MOVE:
            begin
                if (move_ok)
                begin
                    // a move to the current position sends nothing
                    emit           = (shift_cnt != '0);
                    q_cmd.lcd_byte = go_right ? lcs_pkg::INS_SHIFT_RIGHT
                                              : lcs_pkg::INS_SHIFT_LEFT;
                    q_cmd.count    = shift_cnt;
                    cursor_next    = target;
                end
            end
            lcs_pkg::REQ_CHAR:
            begin
                emit          = 1'b1;
                q_cmd.is_data = 1'b1;
                if (cursor_reg < lcs_pkg::MAX_CURSOR)
                begin
                    cursor_next = cursor_reg + 6'd1;
                end
            end
            lcs_pkg::REQ_RAW:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign q_push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lcs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module lcs_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lcs_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output lcs_pkg::cmd_t      head_cmd
);

    lcs_pkg::cmd_t                entry_reg [lcs_pkg::QUEUE_DEPTH];
    logic [lcs_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lcs_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lcs_pkg::QCNT_W-1:0]   cnt_reg;
    logic [lcs_pkg::QCNT_W-1:0]   cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = (cnt_reg == lcs_pkg::QCNT_W'(lcs_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

/* rtl/lcs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_back
// Expands the head command into LCD bytes and expander frames, one byte per
// cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module lcs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire lcs_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [39:0]        m_axis_tdata,
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);

    logic [lcs_pkg::COUNT_W-1:0] idx_reg;
    logic [lcs_pkg::COUNT_W-1:0] idx_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic [39:0]                 data_reg;
    logic [39:0]                 data_next;
    logic                        is_data_reg;
    logic                        last_reg;
    logic                        last_next;
    logic                        advance;
    logic [7:0]                  cur_byte;
    logic [7:0]                  hi;
    logic [7:0]                  lo;
    logic [7:0]                  base;

    assign advance   = !valid_reg || m_axis_tready;
    assign cur_byte  = head_cmd.init_seq ? lcs_pkg::init_byte(idx_reg[lcs_pkg::IDX_W-1:0])
                                         : head_cmd.lcd_byte;
    assign last_next = (idx_reg == head_cmd.count - 6'd1);
    assign hi        = cur_byte & 8'hF0;
    assign lo        = {cur_byte[3:0], 4'h0};
    assign base      = lcs_pkg::FRM_BACKLIGHT | (head_cmd.is_data ? lcs_pkg::FRM_RS : 8'h00);

    assign data_next = {lo | base,
                        lo | base | lcs_pkg::FRM_ENABLE,
                        hi | base,
                        hi | base | lcs_pkg::FRM_ENABLE,
                        cur_byte};

    always_comb
    begin
        pop        = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                if (last_next)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && head_valid)
        begin
            data_reg    <= data_next;
            is_data_reg <= head_cmd.is_data;
            last_reg    <= last_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = is_data_reg;
    assign m_axis_tlast  = last_reg;

endmodule
`default_nettype wire

/* rtl/char_lcd_command_sequencer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer_top
// Turns LCD requests into LCD bytes and 4-bit expander frames.
// ----------------------------------------------------------------------------
// Result path: an accepted request is pushed into the queue, and its first result
//   is registered in the output register, when the queue and that register are empty.
// Throughput: one LCD byte per cycle out of the back end while m_axis_tready is
//   high; a request of n bytes holds the back end for all n bytes (up to 63 for a
//   cursor move, 9 for init). The two-entry command queue lets the front take requests meanwhile.
// Reset: clears the cursor to 0, empties the queue, drops output valid.
// ----------------------------------------------------------------------------
module char_lcd_command_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // char_code[7:0], column[12:8], line[14:13], 0
    input  wire logic [2:0]  s_axis_tuser,  // req_type[2:0]
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // lcd_byte, frame_high_en, frame_high_idle,
                                            // frame_low_en, frame_low_idle
    output logic             m_axis_tuser,  // is_data
    output logic             m_axis_tlast   // last byte of the request
);

    logic          q_full;
    logic          q_push;
    lcs_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          head_valid;
    lcs_pkg::cmd_t head_cmd;

    // Classify the request, update the cursor, drop requests that send nothing
    lcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    // Hold commands between the two sides so each can stall on its own
    lcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Advance through the head command one byte at a time
    lcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
